FILE: rtl/spaced_random_value_generator_top_assert.svh
// Assertion macros for the spaced random value generator.
// Expects clk and rst_n in the scope of the module that includes it.
`ifndef SPACED_RANDOM_VALUE_GENERATOR_TOP_ASSERT_SVH
`define SPACED_RANDOM_VALUE_GENERATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRVG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srvg: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SRVG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srvg: next-cycle check failed");

`endif

FILE: rtl/srvg_pkg.sv
// Package for the spaced random value generator: widths, register
// indexes, reset values and generator constants. No dependencies.
package srvg_pkg;

    localparam int unsigned SEED_W  = 32;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned CFG_W   = 15;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned SPAN_W  = 16;

    typedef logic [IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_MAG_LIMIT = 2'd0;
    localparam cfg_idx_t REG_GAP_MIN   = 2'd1;

    localparam logic [CFG_W-1:0] MAG_LIMIT_RST = 15'd24444;
    localparam logic [CFG_W-1:0] GAP_MIN_RST   = 15'd800;

    localparam logic [SEED_W-1:0] LCG_MUL = 32'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD = 32'd12345;
    localparam logic [SEED_W-1:0] LCG_MOD = 32'hFFFF_FFFF;

endpackage

FILE: rtl/spaced_random_value_generator_top.sv
// Spaced random value generator, top level and only module.
// Depends on srvg_pkg and spaced_random_value_generator_top_assert.svh.
//
// Usage:
//   Input beat on s_* carries a 32-bit signed seed. Output beat on m_*
//   carries the 16-bit signed value (m_tdata) and the retry-cap flag
//   (m_tuser). Registers magnitude limit (index 0) and minimum gap
//   (index 1) are written over cfg_*; write them only between draws.
//   One shared restoring divider (one quotient bit per cycle) forms the first
//   candidate, unless the limit is zero, and the candidate of every search
//   pass; one 32x32 multiplier advances the congruential state.
//   m_tvalid rises once the first candidate is accepted (with a zero limit
//   the division is skipped) or after further search passes (up to
//   MAX_RETRIES passes). s_tready is high only between draws.
//   The finished beat sits in an output register; a stall on m_tready
//   holds that beat, and a following draw waits at its end until the
//   register is free. Reset restores the register defaults, clears the
//   previous value to zero and empties the output register.
module spaced_random_value_generator_top #(
    parameter int unsigned MAX_RETRIES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Input stream; s_tdata: [31:0] seed
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [srvg_pkg::SEED_W-1:0] s_tdata,
    // Output stream; m_tdata: [15:0] value; m_tuser: [0] retry_exhausted
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [srvg_pkg::VALUE_W-1:0] m_tdata,
    output logic                        m_tuser,
    // Configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  srvg_pkg::cfg_idx_t          cfg_index,
    input  logic [srvg_pkg::CFG_W-1:0]  cfg_data
);

    `include "spaced_random_value_generator_top_assert.svh"

    localparam int unsigned PASS_W = $clog2(MAX_RETRIES + 1);
    localparam int unsigned CNT_W  = $clog2(srvg_pkg::SEED_W);
    localparam logic [PASS_W-1:0] PASS_LIMIT = PASS_W'(MAX_RETRIES);
    localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(srvg_pkg::SEED_W - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_RES    = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_MIX    = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    // Control state
    logic [2:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [PASS_W-1:0]           passes_reg, passes_next;
    logic [srvg_pkg::CFG_W-1:0]  mag_limit_reg, gap_min_reg;
    logic [srvg_pkg::VALUE_W-1:0] prev_reg;
    logic                        out_valid_reg, out_valid_next;

    // Datapath
    logic [srvg_pkg::SEED_W-1:0]  s_reg, s_next;
    logic [srvg_pkg::SEED_W-1:0]  dvd_reg, dvd_next;
    logic [srvg_pkg::SPAN_W-1:0]  div_reg, div_next;
    logic [srvg_pkg::SPAN_W-1:0]  rem_reg, rem_next;
    logic [srvg_pkg::SEED_W-1:0]  prod_reg, prod_next;
    logic                         neg_reg, neg_next;
    logic [srvg_pkg::VALUE_W-1:0] cand_reg, cand_next;
    logic [srvg_pkg::VALUE_W-1:0] value_reg;
    logic                         exh_reg, exh_next;
    logic                         exh_out_reg;

    logic                         in_beat, cfg_beat, load_out;
    logic [srvg_pkg::SPAN_W:0]    shifted, trial;
    logic [srvg_pkg::SPAN_W:0]    cand_pass;
    logic [srvg_pkg::SPAN_W:0]    diff, mag;
    logic                         spaced;
    logic [srvg_pkg::SEED_W-1:0]  mixed;
    logic [srvg_pkg::SEED_W-1:0]  seed_mag;

    assign in_beat   = s_tvalid && s_tready;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = value_reg;
    assign m_tuser   = exh_out_reg;
    assign load_out  = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    // Shared divider step: shift in one dividend bit, subtract if it fits
    assign shifted = {rem_reg, dvd_reg[srvg_pkg::SEED_W-1]};
    assign trial   = shifted - {1'b0, div_reg};

    // Search pass candidate: remainder minus the magnitude limit
    assign cand_pass = {1'b0, rem_reg} - {2'b00, mag_limit_reg};

    // Spacing test against the previous output
    assign diff   = {cand_reg[srvg_pkg::VALUE_W-1], cand_reg}
                  - {prev_reg[srvg_pkg::VALUE_W-1], prev_reg};
    assign mag    = diff[srvg_pkg::SPAN_W] ? (~diff + 1'b1) : diff;
    assign spaced = (mag >= {2'b00, gap_min_reg});

    // Congruential step tail: add, then fold the modulus value to zero
    assign mixed = prod_reg + srvg_pkg::LCG_ADD;

    assign seed_mag = s_tdata[srvg_pkg::SEED_W-1] ? (~s_tdata + 1'b1) : s_tdata;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        passes_next    = passes_reg;
        out_valid_next = out_valid_reg;
        s_next         = s_reg;
        dvd_next       = dvd_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        cand_next      = cand_reg;
        exh_next       = exh_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    s_next      = s_tdata;
                    dvd_next    = seed_mag;
                    div_next    = {1'b0, mag_limit_reg};
                    rem_next    = '0;
                    neg_next    = s_tdata[srvg_pkg::SEED_W-1];
                    cnt_next    = '0;
                    passes_next = '0;
                    if (mag_limit_reg == '0)
                    begin
                        // Zero maximum: candidate is zero, skip the division
                        cand_next  = '0;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                dvd_next = {dvd_reg[srvg_pkg::SEED_W-2:0], 1'b0};
                rem_next = trial[srvg_pkg::SPAN_W] ? shifted[srvg_pkg::SPAN_W-1:0]
                                                   : trial[srvg_pkg::SPAN_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                if (passes_reg == '0)
                begin
                    // Truncating remainder takes the sign of the seed
                    cand_next = neg_reg ? (~rem_reg + 1'b1) : rem_reg;
                end
                else
                begin
                    cand_next = cand_pass[srvg_pkg::VALUE_W-1:0];
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (spaced)
                begin
                    exh_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (passes_reg == PASS_LIMIT)
                begin
                    exh_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = s_reg * srvg_pkg::LCG_MUL;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                s_next      = (mixed == srvg_pkg::LCG_MOD) ? '0 : mixed;
                dvd_next    = (mixed == srvg_pkg::LCG_MOD) ? '0 : mixed;
                div_next    = {mag_limit_reg, 1'b1};
                rem_next    = '0;
                cnt_next    = '0;
                passes_next = passes_reg + 1'b1;
                state_next  = ST_DIV;
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            passes_reg    <= '0;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            passes_reg    <= passes_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                prev_reg <= cand_reg;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_limit_reg <= srvg_pkg::MAG_LIMIT_RST;
            gap_min_reg   <= srvg_pkg::GAP_MIN_RST;
        end
        else if (cfg_beat)
        begin
            unique case (cfg_index)
                srvg_pkg::REG_MAG_LIMIT: mag_limit_reg <= cfg_data;
                srvg_pkg::REG_GAP_MIN:   gap_min_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Payload registers; hold the output beat apart from the working flag
    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        dvd_reg  <= dvd_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        cand_reg <= cand_next;
        exh_reg  <= exh_next;
        if (load_out)
        begin
            value_reg   <= cand_reg;
            exh_out_reg <= exh_reg;
        end
    end

    // Checks
    `SRVG_ASSERT_NEXT(a_busy_after_beat, in_beat, state_reg != ST_IDLE)
    `SRVG_ASSERT_NEXT(a_prev_tracks_out, load_out, prev_reg == m_tdata)
    `SRVG_ASSERT_SAME(a_pass_bound, 1'b1, passes_reg <= PASS_LIMIT)
    `SRVG_ASSERT_SAME(a_value_range, m_tvalid,
        ($signed(m_tdata) <= $signed({1'b0, mag_limit_reg})) &&
        ($signed(m_tdata) >= -$signed({1'b0, mag_limit_reg})))
    `SRVG_ASSERT_NEXT(a_hold_beat, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for spaced_random_value_generator_top.
// Needs srvg_pkg and the top module; drives seed beats, checks each result
// against a built-in copy of the draw and retry search.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD  = 10;
    localparam int          RETRY_CAP   = 64;
    localparam int          ITEM_TARGET = 1800;
    // Slowest draw: first candidate plus every search pass
    localparam int          WORST_DRAW  = 35 + 36 * RETRY_CAP;
    localparam int          IDLE_LIMIT  = 4 * (WORST_DRAW + 40 + 16 + 64);
    localparam int          END_SLACK   = 64;
    localparam int          PRINT_CAP   = 100;

    localparam logic [31:0] LCG_A       = 32'd1103515245;
    localparam logic [31:0] LCG_C       = 32'd12345;
    localparam logic [31:0] LCG_FOLD    = 32'hFFFF_FFFF;

    // Indexes that the block decodes to nothing
    localparam srvg_pkg::cfg_idx_t REG_SPARE_2 = 2'd2;
    localparam srvg_pkg::cfg_idx_t REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [srvg_pkg::VALUE_W-1:0] value;
        logic                         exhausted;
    } draw_t;

    typedef enum logic {ROW_SEED, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                    kind;
        srvg_pkg::cfg_idx_t           idx;
        logic [srvg_pkg::CFG_W-1:0]   data;
        logic [srvg_pkg::SEED_W-1:0]  seed;
        bit                           typed;
        draw_t                        want;
    } stim_row_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [srvg_pkg::SEED_W-1:0]  s_tdata   = '0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [srvg_pkg::VALUE_W-1:0] m_tdata;
    logic                         m_tuser;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    srvg_pkg::cfg_idx_t           cfg_index = srvg_pkg::REG_MAG_LIMIT;
    logic [srvg_pkg::CFG_W-1:0]   cfg_data  = '0;

    // Mirror of the block's registers and state
    logic [srvg_pkg::CFG_W-1:0]   mirror_max = srvg_pkg::MAG_LIMIT_RST;
    logic [srvg_pkg::CFG_W-1:0]   mirror_gap = srvg_pkg::GAP_MIN_RST;
    int                           prev_value = 0;

    draw_t                  expected_draws[$];
    stim_row_t              directed_rows[$];
    int                     mismatch_count = 0;
    int                     burst_left     = 0;
    int                     idle_cycles    = 0;

    spaced_random_value_generator_top #(
        .MAX_RETRIES (RETRY_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------
    // Draw prediction
    // ---------------------------------------------------------------
    function automatic bit far_enough(input int cand);
        int gap_abs;
        begin
            gap_abs = cand - prev_value;
            if (gap_abs < 0)
                gap_abs = -gap_abs;
            return gap_abs >= int'(mirror_gap);
        end
    endfunction

    // Work out one draw and advance the previous value
    function automatic draw_t predict_draw(input logic [srvg_pkg::SEED_W-1:0] seed);
        logic [31:0] lcg;
        logic [31:0] span;
        int          cand;
        int          passes;
        draw_t       res;
        begin
            lcg           = seed;
            passes        = 0;
            res.exhausted = 1'b0;
            if (mirror_max == '0)
                cand = 0;
            else
                cand = $signed(seed) % int'(mirror_max);
            if (!far_enough(cand))
            begin
                span = {16'd0, mirror_max, 1'b1};
                do
                begin
                    lcg    = lcg * LCG_A + LCG_C;
                    lcg    = lcg % LCG_FOLD;
                    cand   = int'(lcg % span) - int'(mirror_max);
                    passes = passes + 1;
                end while (!far_enough(cand) && passes < RETRY_CAP);
                res.exhausted = !far_enough(cand);
            end
            prev_value = cand;
            res.value  = cand[srvg_pkg::VALUE_W-1:0];
            return res;
        end
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what);
        begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
                $display("MISMATCH at %0t ns: %s", $time, what);
        end
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        draw_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_draws.size() == 0)
                report_mismatch($sformatf("unexpected beat value=%0d flag=%0b",
                                          $signed(m_tdata), m_tuser));
            else
            begin
                want = expected_draws.pop_front();
                if (m_tdata !== want.value)
                    report_mismatch($sformatf("value got %0d want %0d",
                                              $signed(m_tdata), $signed(want.value)));
                if (m_tuser !== want.exhausted)
                    report_mismatch($sformatf("retry flag got %0b want %0b",
                                              m_tuser, want.exhausted));
            end
        end
    end

    // Stop the run once nothing has moved on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall on a rotating pattern, refreshed now and then
    // ---------------------------------------------------------------
    logic [15:0] stall_pat = 16'hFFFF;
    int          pat_age   = 0;

    always @(negedge clk)
    begin
        if (pat_age == 0)
        begin
            pat_age = $urandom_range(16, 200);
            case ($urandom_range(0, 3))
                0:       stall_pat = 16'hFFFF;
                1:       stall_pat = 16'h00FF;
                default: stall_pat = 16'($urandom) | 16'h0001;
            endcase
        end
        pat_age   = pat_age - 1;
        m_tready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
    end

    // ---------------------------------------------------------------
    // Sender and register writes
    // ---------------------------------------------------------------
    // Present one seed beat and hold it until accepted, then queue its result
    task automatic send_seed(input logic [srvg_pkg::SEED_W-1:0] seed, input bit typed,
                             input draw_t want);
        int    gap;
        draw_t model;
        begin
            @(negedge clk);
            if (burst_left == 0)
            begin
                gap       = $urandom_range(1, 40);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(1, 10);
            end
            burst_left = burst_left - 1;
            s_tvalid  <= 1'b1;
            s_tdata   <= seed;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            model = predict_draw(seed);
            expected_draws.push_back(typed ? want : model);
        end
    endtask

    // Drop the input and wait until every result has come back
    task automatic wait_drained();
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            while (expected_draws.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic write_reg(input srvg_pkg::cfg_idx_t idx,
                             input logic [srvg_pkg::CFG_W-1:0] data);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                srvg_pkg::REG_MAG_LIMIT: mirror_max = data;
                srvg_pkg::REG_GAP_MIN:   mirror_gap = data;
                default:                 ;
            endcase
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------
    task automatic add_seed(input logic [srvg_pkg::SEED_W-1:0] seed);
        stim_row_t row;
        begin
            row       = '{kind: ROW_SEED, idx: srvg_pkg::REG_MAG_LIMIT, data: '0,
                          seed: seed, typed: 1'b0, want: '0};
            directed_rows.push_back(row);
        end
    endtask

    task automatic add_typed(input logic [srvg_pkg::SEED_W-1:0] seed, input int value,
                             input bit flag);
        stim_row_t row;
        begin
            row       = '{kind: ROW_SEED, idx: srvg_pkg::REG_MAG_LIMIT, data: '0,
                          seed: seed, typed: 1'b1, want: '0};
            row.want.value     = value[srvg_pkg::VALUE_W-1:0];
            row.want.exhausted = flag;
            directed_rows.push_back(row);
        end
    endtask

    task automatic add_cfg(input srvg_pkg::cfg_idx_t idx,
                           input logic [srvg_pkg::CFG_W-1:0] data);
        stim_row_t row;
        begin
            row = '{kind: ROW_CFG, idx: idx, data: data, seed: '0,
                    typed: 1'b0, want: '0};
            directed_rows.push_back(row);
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int                           items_done;
        int                           phase_items;
        int                           roll;
        logic [srvg_pkg::CFG_W-1:0]   new_max;
        logic [srvg_pkg::CFG_W-1:0]   new_gap;
        logic [srvg_pkg::SEED_W-1:0]  seed;
        stim_row_t                    row;

        // Reset defaults, previous value zero
        add_typed(32'd1000000, 22240, 1'b0);
        add_typed(32'hFFF0_BDC0, -22240, 1'b0);
        add_typed(32'd0, 0, 1'b0);
        // Same candidate as previous value: search from a zero seed
        add_seed(32'd0);
        add_seed(32'h7FFF_FFFF);
        add_seed(32'h8000_0000);
        add_seed(32'hFFFF_FFFF);
        add_seed(32'hFFFF_FFFF);
        // Undecoded indexes leave both registers alone
        add_cfg(REG_SPARE_2, 15'h7FFF);
        add_cfg(REG_SPARE_3, 15'h0000);
        add_seed(32'd24444);
        // Zero maximum: always zero, and never spaced once an interval is set
        add_cfg(srvg_pkg::REG_MAG_LIMIT, 15'd0);
        add_cfg(srvg_pkg::REG_GAP_MIN, 15'd0);
        add_typed(32'h1234_5678, 0, 1'b0);
        add_cfg(srvg_pkg::REG_GAP_MIN, 15'd1);
        add_typed(32'hDEAD_BEEF, 0, 1'b1);
        // Both registers at full scale: retry cap is hit
        add_cfg(srvg_pkg::REG_MAG_LIMIT, 15'h7FFF);
        add_cfg(srvg_pkg::REG_GAP_MIN, 15'h7FFF);
        add_seed(32'h7FFF_FFFF);
        add_seed(32'h8000_0000);
        add_seed(32'd5);
        // Smallest span with an interval that needs the far end
        add_cfg(srvg_pkg::REG_MAG_LIMIT, 15'd1);
        add_cfg(srvg_pkg::REG_GAP_MIN, 15'd2);
        add_seed(32'd1);
        add_seed(32'hFFFF_FFFF);
        add_seed(32'd0);
        add_seed(32'd3);
        // Zero interval: first candidate always taken
        add_cfg(srvg_pkg::REG_MAG_LIMIT, 15'd24444);
        add_cfg(srvg_pkg::REG_GAP_MIN, 15'd0);
        add_typed(32'd0, 0, 1'b0);
        add_typed(32'h0000_ABCD, 19537, 1'b0);

        // Hold reset, then release at a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(row.idx, row.data);
            end
            else
                send_seed(row.seed, row.typed, row.want);
        end

        // Random phases, each under its own register setting
        items_done = 0;
        while (items_done < ITEM_TARGET)
        begin
            roll = $urandom_range(0, 9);
            if (roll <= 4)
            begin
                // Loose interval: few search passes
                new_max     = 15'($urandom_range(1, 32767));
                new_gap     = 15'($urandom_range(0, int'(new_max) / 2));
                phase_items = $urandom_range(120, 200);
            end
            else if (roll == 5)
            begin
                new_max     = 15'h7FFF;
                new_gap     = 15'($urandom_range(0, 16383));
                phase_items = 100;
            end
            else if (roll == 6)
            begin
                // Tiny span
                new_max     = 15'($urandom_range(1, 16));
                new_gap     = 15'($urandom_range(0, int'(new_max)));
                phase_items = 100;
            end
            else if (roll == 7)
            begin
                new_max     = 15'($urandom_range(1, 32767));
                new_gap     = '0;
                phase_items = 100;
            end
            else if (roll == 8)
            begin
                // Mostly unreachable interval: keep these phases short
                new_max     = $urandom_range(0, 1) ? 15'd0 : 15'($urandom_range(1, 32767));
                new_gap     = 15'($urandom_range(16384, 32767));
                phase_items = $urandom_range(3, 8);
            end
            else
            begin
                // Tight but reachable: several passes, the odd cap hit
                new_max     = 15'($urandom_range(64, 32767));
                new_gap     = 15'($urandom_range(int'(new_max) / 2,
                                                 (int'(new_max) * 3) / 4));
                phase_items = 40;
            end

            wait_drained();
            if ($urandom_range(0, 1))
            begin
                write_reg(srvg_pkg::REG_MAG_LIMIT, new_max);
                write_reg(srvg_pkg::REG_GAP_MIN, new_gap);
            end
            else
            begin
                write_reg(srvg_pkg::REG_GAP_MIN, new_gap);
                write_reg(srvg_pkg::REG_MAG_LIMIT, new_max);
            end

            repeat (phase_items)
            begin
                case ($urandom_range(0, 15))
                    0:       seed = 32'h8000_0000;
                    1:       seed = 32'h7FFF_FFFF;
                    2:       seed = 32'hFFFF_FFFF;
                    3:       seed = 32'h0000_0000;
                    4:       seed = $urandom_range(0, 65535);
                    5:       seed = -$urandom_range(0, 65535);
                    default: seed = $urandom;
                endcase
                send_seed(seed, 1'b0, '0);
                items_done++;
            end
        end

        // Drain, then let the block settle before the verdict
        wait_drained();
        repeat (END_SLACK) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/srvg_pkg.sv
rtl/spaced_random_value_generator_top.sv
tb/sv/tb.sv
